[hdl/ipid_pkg.sv]
// Shared definitions for the multichannel incremental PID core.
// Holds the gain register layout, register indexes and default parameter values.
// No dependencies.
package ipid_pkg;

  localparam int GAIN_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam int CHANNELS_DEFAULT = 4;
  localparam int SPEED_WIDTH_DEFAULT = 16;
  localparam int FRAC_BITS_DEFAULT = 8;

  // Gain reset values in whole units; they are scaled by the fraction bits.
  localparam int KP_RESET_UNITS = 2;
  localparam int KI_RESET_UNITS = 4;
  localparam int KD_RESET_UNITS = 2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_KP = 2'd0,
    REG_KI = 2'd1,
    REG_KD = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [GAIN_WIDTH-1:0] kp;
    logic [GAIN_WIDTH-1:0] ki;
    logic [GAIN_WIDTH-1:0] kd;
  } gains_t;

endpackage

[hdl/ipid_calc.sv]
// Combinational datapath of the incremental PID: error, three gain products,
// rounding and saturation of the drive value.
// Depends on ipid_pkg for the gain width and the gains_t type.
module ipid_calc #(
  parameter int SPEED_WIDTH = ipid_pkg::SPEED_WIDTH_DEFAULT,
  parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEFAULT
) (
  input  ipid_pkg::gains_t                gains,
  input  logic signed [SPEED_WIDTH-1:0]   target_speed,
  input  logic signed [SPEED_WIDTH-1:0]   measured_speed,
  input  logic signed [SPEED_WIDTH:0]     e1,
  input  logic signed [SPEED_WIDTH:0]     e2,
  output logic signed [SPEED_WIDTH-1:0]   drive_value,
  output logic signed [SPEED_WIDTH:0]     err,
  output logic                            update
);

  localparam int GW = ipid_pkg::GAIN_WIDTH;
  localparam int E_W = SPEED_WIDTH + 1;
  localparam int D1_W = E_W + 1;
  localparam int D2_W = E_W + 2;
  localparam int P_W = GW + 1 + D2_W;
  localparam int ACC_W = P_W + 2;
  localparam int ROUND_SHIFT = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
  localparam logic signed [ACC_W-1:0] ROUND =
    (FRAC_BITS > 0) ? (ACC_W'(1) << ROUND_SHIFT) : '0;
  localparam logic signed [ACC_W:0] SMAX =
    {{(ACC_W + 2 - SPEED_WIDTH){1'b0}}, {(SPEED_WIDTH - 1){1'b1}}};
  localparam logic signed [ACC_W:0] SMIN = ~SMAX;

  logic signed [D1_W-1:0]       d1;
  logic signed [D2_W-1:0]       d2;
  logic signed [GW:0]           kp_s;
  logic signed [GW:0]           ki_s;
  logic signed [GW:0]           kd_s;
  logic signed [GW+D1_W:0]      p_p;
  logic signed [GW+E_W:0]       p_i;
  logic signed [P_W-1:0]        p_d;
  logic signed [ACC_W-1:0]      acc;
  logic signed [ACC_W-1:0]      inc;
  logic signed [ACC_W:0]        res;
  logic signed [SPEED_WIDTH-1:0] sat;

  always_comb begin
    err = E_W'(target_speed) - E_W'(measured_speed);
    d1 = D1_W'(err) - D1_W'(e1);
    d2 = D2_W'(err) - (D2_W'(e1) <<< 1) + D2_W'(e2);
    kp_s = $signed({1'b0, gains.kp});
    ki_s = $signed({1'b0, gains.ki});
    kd_s = $signed({1'b0, gains.kd});
    p_p = kp_s * d1;
    p_i = ki_s * err;
    p_d = kd_s * d2;
    acc = ACC_W'(p_p) + ACC_W'(p_i) + ACC_W'(p_d) + ROUND;
    inc = acc >>> FRAC_BITS;
    res = (ACC_W + 1)'(measured_speed) + (ACC_W + 1)'(inc);
    if (res > SMAX) begin
      sat = SMAX[SPEED_WIDTH-1:0];
    end else if (res < SMIN) begin
      sat = SMIN[SPEED_WIDTH-1:0];
    end else begin
      sat = res[SPEED_WIDTH-1:0];
    end
    update = (target_speed != '0);
    drive_value = update ? sat : '0;
  end

endmodule

[hdl/incremental_pid_multichannel_core.sv]
// Top level of the multichannel incremental PID core: handshake, gain
// registers, per-channel error history and the result register.
// Depends on ipid_pkg and ipid_calc.
//
// Each input word names a channel and carries a target and a measured speed.
// The core answers every word with exactly one drive value, in order.
// A word is taken when item_valid is high and item_stall is low; a result
// is taken when result_valid is high and result_stall is low.
// A word waits in the input register, where the error history of its
// channel is read and updated, and moves on to the result register when
// that register is empty or its word is being taken in the same cycle.
// One word is accepted in every cycle unless the receiver stalls; the rate
// is set by one pass through the three gain multipliers and saturating adder.
// Words for the same channel may follow each other in consecutive cycles.
// While the receiver stalls, the result register holds its word and the
// input register can still take one more word; after that item_stall rises.
// Reset clears both registers, the error history of all channels and
// loads the gains with 2.0, 4.0 and 2.0. Gain writes are taken at any edge.
module incremental_pid_multichannel_core #(
  parameter int CHANNELS = ipid_pkg::CHANNELS_DEFAULT,
  parameter int SPEED_WIDTH = ipid_pkg::SPEED_WIDTH_DEFAULT,
  parameter int FRAC_BITS = ipid_pkg::FRAC_BITS_DEFAULT,
  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic [CH_W-1:0]                       channel,
  input  logic signed [SPEED_WIDTH-1:0]         target_speed,
  input  logic signed [SPEED_WIDTH-1:0]         measured_speed,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [SPEED_WIDTH-1:0]         drive_value,
  input  logic                                  wr_en,
  input  logic [ipid_pkg::CFG_INDEX_WIDTH-1:0]  wr_index,
  input  logic [ipid_pkg::GAIN_WIDTH-1:0]       wr_data
);

  localparam int GW = ipid_pkg::GAIN_WIDTH;
  localparam int E_W = SPEED_WIDTH + 1;
  localparam logic [GW-1:0] KP_RESET = GW'(64'(ipid_pkg::KP_RESET_UNITS) << FRAC_BITS);
  localparam logic [GW-1:0] KI_RESET = GW'(64'(ipid_pkg::KI_RESET_UNITS) << FRAC_BITS);
  localparam logic [GW-1:0] KD_RESET = GW'(64'(ipid_pkg::KD_RESET_UNITS) << FRAC_BITS);

  ipid_pkg::gains_t gains;

  logic                          a_valid;
  logic [CH_W-1:0]               a_channel;
  logic signed [SPEED_WIDTH-1:0] a_target;
  logic signed [SPEED_WIDTH-1:0] a_measured;

  logic signed [E_W-1:0] prev_err [CHANNELS];
  logic signed [E_W-1:0] prev_err2 [CHANNELS];

  logic                          out_free;
  logic                          a_fire;
  logic                          accept;
  logic [CH_W:0]                 ch_ext;
  logic [CH_W:0]                 ch_mod;
  logic signed [SPEED_WIDTH-1:0] calc_drive;
  logic signed [E_W-1:0]         calc_err;
  logic                          calc_update;

  always_comb begin
    out_free = !result_valid || !result_stall;
    a_fire = a_valid && out_free;
    item_stall = a_valid && !out_free;
    accept = item_valid && !item_stall;
    ch_ext = {1'b0, channel};
    ch_mod = (ch_ext >= (CH_W + 1)'(CHANNELS)) ? ch_ext - (CH_W + 1)'(CHANNELS) : ch_ext;
  end

  ipid_calc #(
    .SPEED_WIDTH(SPEED_WIDTH),
    .FRAC_BITS(FRAC_BITS)
  ) u_calc (
    .gains(gains),
    .target_speed(a_target),
    .measured_speed(a_measured),
    .e1(prev_err[a_channel]),
    .e2(prev_err2[a_channel]),
    .drive_value(calc_drive),
    .err(calc_err),
    .update(calc_update)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.kp <= KP_RESET;
      gains.ki <= KI_RESET;
      gains.kd <= KD_RESET;
    end else if (wr_en) begin
      case (wr_index)
        ipid_pkg::REG_KP: gains.kp <= wr_data;
        ipid_pkg::REG_KI: gains.ki <= wr_data;
        ipid_pkg::REG_KD: gains.kd <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_fire) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_channel <= ch_mod[CH_W-1:0];
      a_target <= target_speed;
      a_measured <= measured_speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        prev_err[i] <= '0;
        prev_err2[i] <= '0;
      end
    end else if (a_fire && calc_update) begin
      prev_err2[a_channel] <= prev_err[a_channel];
      prev_err[a_channel] <= calc_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (a_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      drive_value <= calc_drive;
    end
  end

`ifndef SYNTHESIS
  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> a_valid && result_valid)
    else $error("input stalled without both registers full");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    a_fire |=> result_valid)
    else $error("forwarded word did not reach the result register");

  a_zero_target_zero_drive: assert property (@(posedge clk) disable iff (rst)
    a_fire && a_target == '0 |=> drive_value == '0)
    else $error("zero target did not give a zero drive value");

  a_history_update: assert property (@(posedge clk) disable iff (rst)
    a_fire && calc_update |=> prev_err[$past(a_channel)] == $past(calc_err))
    else $error("error history not updated with the new error");

  a_held_word: assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_fire |=> a_valid && $stable(a_target) && $stable(a_channel))
    else $error("waiting word in the input register changed");
`endif

endmodule
